>>> sv/brle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_pkg: shared types and constants of the bilevel run-length encoder
// Field widths, run counter cap, register indexes and the result word type.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int unsigned PixelW   = 8;
  localparam int unsigned RunW     = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Largest frame; the run counter saturates at the smaller of this and
  // the full range of the run field.
  localparam longint unsigned MaxFramePixels = 64'd1048576;
  localparam longint unsigned RunFieldMax    = (64'd1 << RunW) - 64'd1;
  localparam longint unsigned RunCapL        =
    (MaxFramePixels < RunFieldMax) ? MaxFramePixels : RunFieldMax;
  localparam logic [RunW-1:0] RunCap         = RunCapL[RunW-1:0];

  localparam logic [PixelW-1:0] DefaultThreshold = 8'h80;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWhiteThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInitialWhite   = 2'd1;

  // Result queue geometry: two results can come from one pixel
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [RunW-1:0] run_length;
    logic            final_run;
  } result_t;

endpackage

>>> sv/bilevel_run_length_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilevel_run_length_encoder_core: bilevel run-length encoder
// Thresholds grey pixels to white/black, emits same-colour run lengths with a
// zero-length lead run if a frame opens off the initial colour, final at frame end.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  input   | in        | in_valid_i / in_stall_o | pixel_i, frame_end_i
//  output  | out       | out_valid_o / out_stall_i | run_length_o, final_run_o
//  config  | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One pixel word per cycle while the input is not stalled: threshold,
//  compare and counter update form one short path from the input port into
//  the result queue registers, whose head drives the output.
//  The 4-entry result queue sets the stall: input stalls while it holds more
//  than two words, since one pixel may push two results.
//  Reset (rst_ni low, asynchronous) clears run state, the queue and the
//  registers (threshold 0x80, initial colour black); no clearing pass.
//
module bilevel_run_length_encoder_core
  import brle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixelW-1:0]   pixel_i,
  input  logic                frame_end_i,
  // run output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RunW-1:0]     run_length_o,
  output logic                final_run_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [PixelW-1:0] thr_q;
  logic              init_white_q;

  // Run state
  logic              cur_white_q, cur_white_d;
  logic [RunW-1:0]   run_cnt_q, run_cnt_d;

  // Result queue
  result_t           q_mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  q_cnt_q, q_cnt_d;

  logic              in_acc, out_acc;
  logic              is_white, cur_eff, chg;
  logic [RunW-1:0]   run_mid;
  result_t           res0, res1;
  logic              push0, push1;
  logic [1:0]        n_push;

  assign cfg_ready_o = 1'b1;

  // Stall while fewer than two free slots remain
  assign in_stall_o  = (q_cnt_q > QCntW'(QDepth - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (q_cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= DefaultThreshold;
      init_white_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegWhiteThreshold: thr_q        <= cfg_data_i;
        RegInitialWhite:   init_white_q <= cfg_data_i[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Colour decision and run update for the accepted pixel
  always_comb begin
    is_white = (pixel_i >= thr_q);
    // An empty run count means no pixel of this frame yet: use initial colour
    cur_eff  = (run_cnt_q == '0) ? init_white_q : cur_white_q;
    chg      = (is_white != cur_eff);

    if (chg) begin
      run_mid = RunW'(1);
    end else if (run_cnt_q < RunCap) begin
      run_mid = run_cnt_q + RunW'(1);
    end else begin
      run_mid = run_cnt_q;
    end

    if (frame_end_i) begin
      run_cnt_d   = '0;
      cur_white_d = init_white_q;
    end else begin
      run_cnt_d   = run_mid;
      cur_white_d = chg ? is_white : cur_eff;
    end

    // First slot takes the finished run on a colour change, else the final
    // run; second slot only when both happen on one pixel.
    res0.run_length = chg ? run_cnt_q : run_mid;
    res0.final_run  = !chg;
    res1.run_length = run_mid;
    res1.final_run  = 1'b1;

    push0  = in_acc && (chg || frame_end_i);
    push1  = in_acc && chg && frame_end_i;
    n_push = {1'b0, push0} + {1'b0, push1};

    q_cnt_d = q_cnt_q + QCntW'(n_push) - QCntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_white_q <= 1'b0;
      run_cnt_q   <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      q_cnt_q     <= '0;
    end else begin
      if (in_acc) begin
        cur_white_q <= cur_white_d;
        run_cnt_q   <= run_cnt_d;
      end
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      q_cnt_q <= q_cnt_d;
    end
  end

  // Queue storage: payload only, no reset
  always_ff @(posedge clk_i) begin
    if (push0) begin
      q_mem[wr_ptr_q] <= res0;
    end
    if (push1) begin
      q_mem[wr_ptr_q + QPtrW'(1)] <= res1;
    end
  end

  assign run_length_o = q_mem[rd_ptr_q].run_length;
  assign final_run_o  = q_mem[rd_ptr_q].final_run;

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // Frame end always leaves the run counter empty
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && frame_end_i |=> run_cnt_q == '0)
    else $error("run count not cleared at frame end");

  // A mid-frame pixel always leaves a nonzero run
  a_run_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !frame_end_i |=> run_cnt_q != '0)
    else $error("run count empty inside a frame");

  // Final pixel always queues at least one result
  a_final_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && frame_end_i && !out_acc |=> q_cnt_q != '0)
    else $error("frame end produced no result");

  // Occupancy holds when nothing moves
  a_q_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc && !out_acc |=> $stable(q_cnt_q))
    else $error("queue count moved without traffic");

endmodule

>>> sim/tb_bilevel_run_length_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilevel_run_length_encoder_core: self-checking bench for the run encoder
// Streams grey pixel words through random source gaps and sink stalls,
// predicts each run word in a local encoder model and checks every word
// on the run output in order.
// ----------------------------------------------------------------------------
module tb_bilevel_run_length_encoder_core;
  import brle_pkg::*;

  // Indexes past the end of the register file; writes there must be ignored
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  // Cycles the sink holds off in the back-pressure phase
  localparam int HoldCycles = 100;

  // One pixel word as queued for the source. When known is set, the run
  // words it causes are typed in (num_known of them) instead of predicted.
  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              frame_end;
    logic              known;
    logic [1:0]        num_known;
    result_t           run_a;
    result_t           run_b;
  } pix_word_t;

  localparam result_t NoRun   = '{run_length: 21'd0, final_run: 1'b0};
  localparam result_t ZeroRun = '{run_length: 21'd0, final_run: 1'b0};
  localparam result_t OneLast = '{run_length: 21'd1, final_run: 1'b1};

  // Directed words, run under the reset settings (threshold 0x80, black
  // start). Single-pixel frames have their runs typed in; the rest is
  // left to the encoder model.
  localparam int NumDirected = 21;
  localparam pix_word_t DirectedTab [NumDirected] = '{
    // black lone pixel matches the start colour: one final run of 1
    '{8'h00, 1'b1, 1'b1, 2'd1, OneLast, NoRun},
    // white lone pixel: leading zero-length run, then the final run
    '{8'hFF, 1'b1, 1'b1, 2'd2, ZeroRun, OneLast},
    // exactly at the threshold counts as white
    '{8'h80, 1'b1, 1'b1, 2'd2, ZeroRun, OneLast},
    // one below the threshold is black
    '{8'h7F, 1'b1, 1'b1, 2'd1, OneLast, NoRun},
    '{8'h01, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h7F, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h80, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'hFE, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'hAA, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h55, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h33, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'hCC, 1'b1, 1'b0, 2'd0, NoRun, NoRun},
    '{8'hFF, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'hFF, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'hF0, 1'b1, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h0F, 1'b1, 1'b1, 2'd1, OneLast, NoRun},
    '{8'h81, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h7E, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h81, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h7E, 1'b0, 1'b0, 2'd0, NoRun, NoRun},
    '{8'h80, 1'b1, 1'b0, 2'd0, NoRun, NoRun}
  };

  // --------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [PixelW-1:0]   pixel_i     = '0;
  logic                frame_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [RunW-1:0]     run_length_o;
  logic                final_run_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  bilevel_run_length_encoder_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .run_length_o (run_length_o),
    .final_run_o  (final_run_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Encoder model: register copies and run state, updated per accepted pixel
  // --------------------------------------------------------------------------
  logic [PixelW-1:0] thr_reg        = DefaultThreshold;
  logic              init_white_reg = 1'b0;
  logic              run_white      = 1'b0;
  logic [RunW-1:0]   run_len        = '0;

  pix_word_t pixel_q [$];   // words waiting to go out on the pixel channel
  result_t   run_q [$];     // run words still owed by the block

  int mismatch_cnt  = 0;
  int src_gap_pct   = 22;   // chance per cycle that the source idles
  int snk_stall_pct = 22;   // chance per cycle that the sink stalls
  bit hold_start    = 1'b0; // kick off one long sink hold-off

  // Random frame generator state, kept across phases so frames straddle them
  int frame_left = 0;
  bit gen_white  = 1'b0;

  // Advance the run state by one pixel; return how many run words it closes.
  function automatic int encode_pixel(input logic [PixelW-1:0] pix,
                                      input logic last,
                                      output result_t first_run,
                                      output result_t second_run);
    logic is_white;
    int   num;
    num        = 0;
    first_run  = NoRun;
    second_run = NoRun;
    is_white   = (pix >= thr_reg);
    // A fresh frame picks up the start colour as it stands now
    if (run_len == '0) run_white = init_white_reg;
    if (is_white != run_white) begin
      first_run = '{run_length: run_len, final_run: 1'b0};
      num       = 1;
      run_white = is_white;
      run_len   = 21'd1;
    end else if (run_len < RunCap) begin
      run_len = run_len + 21'd1;
    end
    if (last) begin
      if (num == 0) first_run = '{run_length: run_len, final_run: 1'b1};
      else second_run = '{run_length: run_len, final_run: 1'b1};
      num       = num + 1;
      run_len   = '0;
      run_white = init_white_reg;
    end
    return num;
  endfunction

  // --------------------------------------------------------------------------
  // Pixel source: predict on acceptance, hold a stalled word, else offer the
  // next queued word unless this cycle is a random gap
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : pixel_src
    pix_word_t w;
    result_t   ra;
    result_t   rb;
    int        num;
    if (in_valid_i && !in_stall_o) begin
      w   = pixel_q.pop_front();
      num = encode_pixel(w.pixel, w.frame_end, ra, rb);
      // Typed-in rows override the model, which still advances its state
      if (w.known) begin
        num = int'(w.num_known);
        ra  = w.run_a;
        rb  = w.run_b;
      end
      if (num > 0) run_q.push_back(ra);
      if (num > 1) run_q.push_back(rb);
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        in_valid_i  <= 1'b1;
        pixel_i     <= pixel_q[0].pixel;
        frame_end_i <= pixel_q[0].frame_end;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run sink: check each accepted word against the oldest expectation, then
  // pick the stall for the next cycle (long hold-off first, if one is due)
  // --------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk_i) begin : run_sink
    result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (run_q.size() == 0) begin
        $display("%0t: unexpected run word, length %0d final %0b",
                 $realtime, run_length_o, final_run_o);
        mismatch_cnt++;
      end else begin
        want = run_q.pop_front();
        if (run_length_o !== want.run_length) begin
          $display("%0t: run_length expected %0d actual %0d",
                   $realtime, want.run_length, run_length_o);
          mismatch_cnt++;
        end
        if (final_run_o !== want.final_run) begin
          $display("%0t: final_run expected %0b actual %0b",
                   $realtime, want.final_run, final_run_o);
          mismatch_cnt++;
        end
      end
    end
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Queue one pixel word, keeping the source queue short
  task automatic queue_word(input pix_word_t w);
    while (pixel_q.size() >= 16) @(posedge clk_i);
    pixel_q.push_back(w);
  endtask

  // Wait until every word is sent and every run has come back, then keep
  // clocking the block for words that close no run
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid_i || run_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register and update the model copy on the handshake
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegWhiteThreshold) thr_reg = val;
    else if (idx == RegInitialWhite) init_white_reg = val[0];
  endtask

  // Set both registers; junk in the upper data bits of the colour register
  task automatic set_regs(input int thr, input bit iw);
    write_reg(RegWhiteThreshold, CfgDataW'(thr));
    write_reg(RegInitialWhite, CfgDataW'(($urandom_range(255) & 8'hFE) | iw));
  endtask

  // Grey value of the wanted colour under the current threshold
  function automatic logic [PixelW-1:0] pick_pixel(input bit white);
    if (white || thr_reg == '0) return PixelW'($urandom_range(255, thr_reg));
    return PixelW'($urandom_range(int'(thr_reg) - 1, 0));
  endfunction

  // Random frames: mostly short, some long; colour runs with occasional noise
  task automatic feed_frames(input int count);
    pix_word_t w;
    int        r;
    for (int k = 0; k < count; k++) begin
      if (frame_left == 0) begin
        r = $urandom_range(99);
        if (r < 70) frame_left = $urandom_range(12, 1);
        else if (r < 95) frame_left = $urandom_range(80, 13);
        else frame_left = $urandom_range(400, 81);
      end
      if ($urandom_range(99) < 30) gen_white = ~gen_white;
      w = '0;
      if ($urandom_range(99) < 15) w.pixel = PixelW'($urandom_range(255));
      else w.pixel = pick_pixel(gen_white);
      w.frame_end = (frame_left == 1);
      frame_left  = frame_left - 1;
      queue_word(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset register values
    for (int k = 0; k < NumDirected; k++) queue_word(DirectedTab[k]);
    drain();

    // Threshold extremes with both start colours; phases end wherever the
    // frame happens to be, so writes also land mid-frame
    set_regs(0, 1'b1);
    feed_frames(90);
    drain();
    set_regs(255, 1'b0);
    feed_frames(90);
    drain();
    set_regs(255, 1'b1);
    // Out-of-range indexes must leave both registers alone
    write_reg(RegSpareA, CfgDataW'($urandom_range(255)));
    write_reg(RegSpareB, CfgDataW'($urandom_range(255)));
    feed_frames(90);
    drain();
    set_regs(0, 1'b0);
    feed_frames(60);
    drain();

    // Full-rate stretch: no gaps, no stalls
    set_regs($urandom_range(255), 1'($urandom_range(1)));
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    feed_frames(150);
    drain();

    // Back-pressure: hold the sink off while the source keeps offering,
    // so the result queue fills and the pixel input stalls
    set_regs(1, 1'b1);
    hold_start = 1'b1;
    feed_frames(60);
    drain();
    src_gap_pct   = 22;
    snk_stall_pct = 22;

    for (int p = 0; p < 4; p++) begin
      set_regs($urandom_range(255), 1'($urandom_range(1)));
      feed_frames(60);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin : run_limit
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
sv/brle_pkg.sv
sv/bilevel_run_length_encoder_core.sv
sim/tb_bilevel_run_length_encoder_core.sv
